[rtl/pff_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the page frame free stack.
// No dependencies; used by every other file of the block.
package pff_pkg;

    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned PAGE_SHIFT = 12;
    localparam int unsigned FRAME_W    = ADDR_W - PAGE_SHIFT;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [ADDR_W-1:0] HOLE_LO    = 32'h0008_0000;
    localparam logic [ADDR_W-1:0] HOLE_HI    = 32'h0010_0000;
    localparam logic [ADDR_W-1:0] KSTART_RST = 32'h0010_0000;
    localparam logic [ADDR_W-1:0] KEND_RST   = 32'h0040_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_KSTART = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEND   = 2'd1;

    typedef enum logic [1:0] {
        FN_ALLOC = 2'd0,
        FN_FREE  = 2'd1,
        FN_RANGE = 2'd2,
        FN_NONE  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_MISALIGNED = 3'd2,
        ST_IGNORED    = 3'd3,
        ST_FULL       = 3'd4
    } t_status;

    typedef struct packed {
        logic [ADDR_W-1:0] kernel_start;
        logic [ADDR_W-1:0] kernel_end;
    } t_cfg;

    // True for addresses that must never enter the stack.
    function automatic logic is_filtered(input logic [ADDR_W-1:0] a, input t_cfg cfg);
        logic in_kernel;
        logic in_hole;
        in_kernel = (a >= cfg.kernel_start) && (a < cfg.kernel_end);
        in_hole   = (a >= HOLE_LO) && (a < HOLE_HI);
        return (a == '0) || in_kernel || in_hole;
    endfunction

endpackage

[rtl/pff_stack_ram.sv]
`timescale 1ns / 1ps
// Single write port, single read port frame store with registered read data.
// Depends on pff_pkg for the frame number width.
module pff_stack_ram #(
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned AW    = 12
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [pff_pkg::FRAME_W-1:0] i_wr_data,
    input  logic                        i_rd_en,
    input  logic [AW-1:0]               i_rd_addr,
    output logic [pff_pkg::FRAME_W-1:0] o_rd_data
);

    logic [pff_pkg::FRAME_W-1:0] r_mem [DEPTH];
    logic [pff_pkg::FRAME_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/pff_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer for the free stack: stack pointer, range walker and result register.
// Depends on pff_pkg and pff_stack_ram.
module pff_ctrl #(
    parameter int unsigned STACK_DEPTH = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pff_pkg::t_cfg               i_cfg,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_func,
    input  logic [pff_pkg::ADDR_W-1:0]  i_addr,
    input  logic [pff_pkg::ADDR_W-1:0]  i_end_addr,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [pff_pkg::ADDR_W-1:0]  o_frame_addr,
    output logic [2:0]                  o_status
);

    localparam int unsigned AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned CW   = $clog2(STACK_DEPTH + 1);
    localparam int unsigned PN_W = pff_pkg::FRAME_W + 1;
    localparam int unsigned PS   = pff_pkg::PAGE_SHIFT;
    localparam int unsigned AD_W = pff_pkg::ADDR_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_RANGE,
        S_HOLD
    } t_state;

    t_state                    r_state, n_state;
    logic [CW-1:0]             r_count, n_count;
    logic [PN_W-1:0]           r_page, n_page;
    logic [AD_W-1:0]           r_end, n_end;
    logic                      r_pushed, n_pushed;
    logic                      r_ignored, n_ignored;
    logic [AD_W-1:0]           r_res_frame, n_res_frame;
    pff_pkg::t_status          r_res_status, n_res_status;
    logic                      r_out_valid, n_out_valid;
    logic [AD_W-1:0]           r_out_frame, n_out_frame;
    pff_pkg::t_status          r_out_status, n_out_status;

    logic                      in_acc;
    logic                      slot_free;
    logic                      full;
    logic [CW-1:0]             cnt_dec;
    logic [AD_W:0]             page_addr;
    logic                      res_ok;
    logic [AD_W-1:0]           res_frame;
    pff_pkg::t_status          res_status;
    logic                      wr_en;
    logic [pff_pkg::FRAME_W-1:0] wr_data;
    logic                      rd_en;
    logic [pff_pkg::FRAME_W-1:0] rd_data;

    pff_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (cnt_dec[AW-1:0]),
        .o_rd_data (rd_data)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign slot_free  = !r_out_valid || !i_out_stall;
    assign full       = (r_count == CW'(STACK_DEPTH));
    assign cnt_dec    = r_count - CW'(1);
    assign page_addr  = {r_page, {PS{1'b0}}};

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_page       = r_page;
        n_end        = r_end;
        n_pushed     = r_pushed;
        n_ignored    = r_ignored;
        n_res_frame  = r_res_frame;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_frame  = r_out_frame;
        n_out_status = r_out_status;
        wr_en        = 1'b0;
        wr_data      = i_addr[AD_W-1:PS];
        rd_en        = 1'b0;
        res_ok       = 1'b0;
        res_frame    = '0;
        res_status   = pff_pkg::ST_OK;

        // Drop the held result once the receiver takes it.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (pff_pkg::t_func'(i_func))
                        pff_pkg::FN_ALLOC: begin
                            if (r_count == '0) begin
                                res_ok     = 1'b1;
                                res_status = pff_pkg::ST_EMPTY;
                            end else begin
                                n_count = cnt_dec;
                                rd_en   = 1'b1;
                                n_state = S_POP;
                            end
                        end
                        pff_pkg::FN_FREE: begin
                            res_ok = 1'b1;
                            if (i_addr[PS-1:0] != '0) begin
                                res_status = pff_pkg::ST_MISALIGNED;
                            end else if (pff_pkg::is_filtered(i_addr, i_cfg)) begin
                                res_status = pff_pkg::ST_IGNORED;
                            end else if (full) begin
                                res_status = pff_pkg::ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        pff_pkg::FN_RANGE: begin
                            if (i_addr >= i_end_addr) begin
                                res_ok = 1'b1;
                            end else if (i_addr[PS-1:0] != '0) begin
                                res_ok     = 1'b1;
                                res_status = pff_pkg::ST_MISALIGNED;
                            end else begin
                                n_page    = {1'b0, i_addr[AD_W-1:PS]};
                                n_end     = i_end_addr;
                                n_pushed  = 1'b0;
                                n_ignored = 1'b0;
                                n_state   = S_RANGE;
                            end
                        end
                        pff_pkg::FN_NONE: begin
                            res_ok = 1'b1;
                        end
                        default: begin
                            res_ok = 1'b1;
                        end
                    endcase
                end
            end
            S_POP: begin
                res_ok    = 1'b1;
                res_frame = {rd_data, {PS{1'b0}}};
            end
            S_RANGE: begin
                if (page_addr >= {1'b0, r_end}) begin
                    res_ok = 1'b1;
                    if (r_pushed) begin
                        res_status = pff_pkg::ST_OK;
                    end else if (r_ignored) begin
                        res_status = pff_pkg::ST_IGNORED;
                    end
                end else if (pff_pkg::is_filtered(page_addr[AD_W-1:0], i_cfg)) begin
                    n_ignored = 1'b1;
                    n_page    = r_page + PN_W'(1);
                end else if (full) begin
                    res_ok     = 1'b1;
                    res_status = pff_pkg::ST_FULL;
                end else begin
                    wr_en    = 1'b1;
                    wr_data  = r_page[pff_pkg::FRAME_W-1:0];
                    n_count  = r_count + CW'(1);
                    n_pushed = 1'b1;
                    n_page   = r_page + PN_W'(1);
                end
            end
            S_HOLD: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_frame  = r_res_frame;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Load the result register, or park the result until it frees up.
        if (res_ok) begin
            if (slot_free) begin
                n_out_valid  = 1'b1;
                n_out_frame  = res_frame;
                n_out_status = res_status;
                n_state      = S_IDLE;
            end else begin
                n_res_frame  = res_frame;
                n_res_status = res_status;
                n_state      = S_HOLD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_page       <= n_page;
        r_end        <= n_end;
        r_pushed     <= n_pushed;
        r_ignored    <= n_ignored;
        r_res_frame  <= n_res_frame;
        r_res_status <= n_res_status;
        r_out_frame  <= n_out_frame;
        r_out_status <= n_out_status;
    end

    assign o_out_valid  = r_out_valid;
    assign o_frame_addr = r_out_frame;
    assign o_status     = r_out_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> !full)
        else $error("push onto a full stack");

    a_pop_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> $past(rd_en))
        else $error("pop result without a stack read");

    a_frame_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_frame != '0)) |-> (r_out_status == pff_pkg::ST_OK))
        else $error("frame address reported with a failing status");

endmodule

[rtl/page_frame_free_stack_top.sv]
`timescale 1ns / 1ps
// Top level of the page frame free stack: configuration registers and sequencer.
// Depends on pff_pkg, pff_stack_ram and pff_ctrl.
//
//   Input channel (i_in_valid / o_in_stall) carries one operation per item:
//   i_func selects alloc, free one page or free range; i_addr and i_end_addr
//   give the page or the range. Each item returns exactly one result item on
//   the output channel (o_out_valid / i_out_stall): o_frame_addr and o_status.
//   Free, the unused code, alloc on an empty stack and an empty or misaligned
//   range: the result is registered at the accepting edge if the output is free.
//   Alloc of a frame reads the frame store at the accepting edge and takes the
//   registered read data in the pop state. Free range walks its pages one page
//   a cycle through the single write port; a full stack ends the walk early.
//   The configuration port (i_cfg_valid / o_cfg_ready, always ready) writes
//   kernel_start at index 0 and kernel_end at index 1; other indexes are
//   ignored. Write it only while the block is idle.
//   Reset empties the stack and restores the kernel bounds; the frame store
//   itself is not cleared, as only entries below the fill count are read.
//   When the receiver stalls, the result holds in the output register while
//   the next item is still taken; a second finished result parks in the
//   sequencer and further items wait until the output register drains.
module page_frame_free_stack_top #(
    parameter int unsigned STACK_DEPTH = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pff_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pff_pkg::ADDR_W-1:0]          i_cfg_data,
    // Operation items
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_func,
    input  logic [pff_pkg::ADDR_W-1:0]          i_addr,
    input  logic [pff_pkg::ADDR_W-1:0]          i_end_addr,
    // Result items
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [pff_pkg::ADDR_W-1:0]          o_frame_addr,
    output logic [2:0]                          o_status
);

    pff_pkg::t_cfg r_cfg;

    // Always ready: a register write completes at the edge that takes it.
    assign o_cfg_ready = 1'b1;

    // Hold the kernel bounds; writes to unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kernel_start <= pff_pkg::KSTART_RST;
            r_cfg.kernel_end   <= pff_pkg::KEND_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                pff_pkg::CFG_KSTART: r_cfg.kernel_start <= i_cfg_data;
                pff_pkg::CFG_KEND:   r_cfg.kernel_end   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Advance operations through the stack sequencer.
    pff_ctrl #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_addr       (i_addr),
        .i_end_addr   (i_end_addr),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_frame_addr (o_frame_addr),
        .o_status     (o_status)
    );

endmodule

[tb/page_frame_free_stack_checker.sv]
`timescale 1ns / 1ps
// Result checker for the page frame free stack: watches all three channels,
// predicts each result item and compares it. Depends on pff_pkg only.
module page_frame_free_stack_checker #(
    parameter int unsigned STACK_DEPTH = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [pff_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pff_pkg::ADDR_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [1:0]                    i_func,
    input  logic [pff_pkg::ADDR_W-1:0]    i_addr,
    input  logic [pff_pkg::ADDR_W-1:0]    i_end_addr,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [pff_pkg::ADDR_W-1:0]    i_frame_addr,
    input  logic [2:0]                    i_status,
    output int                            o_fail_count,
    output int                            o_pending
);

    localparam int unsigned AW = pff_pkg::ADDR_W;
    localparam int unsigned PS = pff_pkg::PAGE_SHIFT;

    typedef struct packed {
        logic [AW-1:0]    frame;
        pff_pkg::t_status status;
    } t_frame_result;

    logic [pff_pkg::FRAME_W-1:0] frame_stack [STACK_DEPTH];
    int unsigned                 fill_count;
    logic [AW-1:0]               kern_start;
    logic [AW-1:0]               kern_end;
    t_frame_result               expected_frames [$];
    int                          fail_count;
    int                          pending_n;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_n;

    function automatic bit frame_reserved(input logic [AW-1:0] a);
        if (a == '0)
            return 1'b1;
        if (a >= kern_start && a < kern_end)
            return 1'b1;
        return (a >= pff_pkg::HOLE_LO) && (a < pff_pkg::HOLE_HI);
    endfunction

    // Push one aligned page; reserved pages are skipped before the full check.
    function automatic pff_pkg::t_status push_frame(input logic [AW-1:0] a);
        if (frame_reserved(a))
            return pff_pkg::ST_IGNORED;
        if (fill_count >= STACK_DEPTH)
            return pff_pkg::ST_FULL;
        frame_stack[fill_count] = a[AW-1:PS];
        fill_count++;
        return pff_pkg::ST_OK;
    endfunction

    function automatic t_frame_result predict_frame_op(input pff_pkg::t_func op,
                                                       input logic [AW-1:0] a,
                                                       input logic [AW-1:0] e);
        t_frame_result    res;
        logic [AW:0]      page;
        bit               any_pushed;
        bit               any_reserved;
        bit               hit_full;
        pff_pkg::t_status st;
        res.frame    = '0;
        res.status   = pff_pkg::ST_OK;
        any_pushed   = 1'b0;
        any_reserved = 1'b0;
        hit_full     = 1'b0;
        case (op)
            pff_pkg::FN_ALLOC: begin
                if (fill_count == 0) begin
                    res.status = pff_pkg::ST_EMPTY;
                end else begin
                    fill_count--;
                    res.frame = {frame_stack[fill_count], {PS{1'b0}}};
                end
            end
            pff_pkg::FN_FREE: begin
                if (a[PS-1:0] != '0)
                    res.status = pff_pkg::ST_MISALIGNED;
                else
                    res.status = push_frame(a);
            end
            pff_pkg::FN_RANGE: begin
                if (a < e) begin
                    if (a[PS-1:0] != '0) begin
                        res.status = pff_pkg::ST_MISALIGNED;
                    end else begin
                        // walk in 33 bits so the range stops at the address top
                        page = {1'b0, a};
                        while (page < {1'b0, e} && !hit_full) begin
                            st = push_frame(page[AW-1:0]);
                            if (st == pff_pkg::ST_OK)
                                any_pushed = 1'b1;
                            else if (st == pff_pkg::ST_IGNORED)
                                any_reserved = 1'b1;
                            else
                                hit_full = 1'b1;
                            page = page + (33'd1 << PS);
                        end
                        if (hit_full)
                            res.status = pff_pkg::ST_FULL;
                        else if (any_pushed)
                            res.status = pff_pkg::ST_OK;
                        else if (any_reserved)
                            res.status = pff_pkg::ST_IGNORED;
                    end
                end
            end
            default: begin
                res.status = pff_pkg::ST_OK;
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_frame_result want;
        if (!i_rst_n) begin
            fill_count = 0;
            kern_start = pff_pkg::KSTART_RST;
            kern_end   = pff_pkg::KEND_RST;
            expected_frames.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_frames.size() == 0) begin
                    $error("result item with nothing outstanding: frame_addr %h status %0d",
                           i_frame_addr, i_status);
                    fail_count++;
                end else begin
                    want = expected_frames.pop_front();
                    if (i_frame_addr !== want.frame) begin
                        $error("frame_addr: expected %h, got %h", want.frame, i_frame_addr);
                        fail_count++;
                    end
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == pff_pkg::CFG_KSTART)
                    kern_start = i_cfg_data;
                else if (i_cfg_index == pff_pkg::CFG_KEND)
                    kern_end = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall)
                expected_frames.push_back(predict_frame_op(pff_pkg::t_func'(i_func),
                                                           i_addr, i_end_addr));
        end
        pending_n = expected_frames.size();
    end

endmodule

[tb/page_frame_free_stack_top_tb.sv]
`timescale 1ns / 1ps
// Top of the page frame free stack testbench: clock, reset, stimulus and verdict.
// Depends on pff_pkg, page_frame_free_stack_top and page_frame_free_stack_checker.
module page_frame_free_stack_top_tb;

    localparam int unsigned AW = pff_pkg::ADDR_W;
    localparam int unsigned IW = pff_pkg::CFG_IDX_W;
    localparam int unsigned PS = pff_pkg::PAGE_SHIFT;

    localparam int unsigned   STACK_DEPTH = 4096;
    localparam logic [AW-1:0] PAGE_MASK   = 32'hFFFF_F000;
    localparam logic [AW-1:0] FILL_BASE   = 32'h0100_0000;
    // index with no register behind it; the block must ignore a write to it
    localparam logic [IW-1:0] CFG_UNUSED = 2'd3;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 220;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [IW-1:0]        i_cfg_index;
    logic [AW-1:0]        i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [1:0]           i_func;
    logic [AW-1:0]        i_addr;
    logic [AW-1:0]        i_end_addr;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [AW-1:0]        o_frame_addr;
    logic [2:0]           o_status;

    int fail_n;
    int pending_n;

    // Stimulus-side copy of the kernel window, used only to aim addresses at its edges.
    logic [AW-1:0] kstart_now;
    logic [AW-1:0] kend_now;
    // calm: neither side idles; hold_req: ask the receiver for its long hold-off
    bit calm;
    bit hold_req;

    page_frame_free_stack_top #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_addr       (i_addr),
        .i_end_addr   (i_end_addr),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_frame_addr (o_frame_addr),
        .o_status     (o_status)
    );

    page_frame_free_stack_checker #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_addr       (i_addr),
        .i_end_addr   (i_end_addr),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_frame_addr (o_frame_addr),
        .i_status     (o_status),
        .o_fail_count (fail_n),
        .o_pending    (pending_n)
    );

    // 8 ns clock, first rising edge at 4 ns.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Pick an address for a free or a range start. Bias towards the filter
    // edges: zero, the low hole and its neighbours, and both kernel bounds.
    function automatic logic [AW-1:0] pick_addr();
        int unsigned   kind;
        logic [AW-1:0] base;
        kind = $urandom_range(0, 99);
        base = $urandom;
        if (kind < 10)
            return base | 32'($urandom_range(1, 12'hFFF));
        if (kind < 14)
            return '0;
        if (kind < 30)
            return pff_pkg::HOLE_LO - 32'h1000 + 32'($urandom_range(0, 129) << PS);
        if (kind < 45) begin
            base = ($urandom_range(0, 1) != 0) ? kstart_now : kend_now;
            return (base & PAGE_MASK) + 32'($urandom_range(0, 4) << PS) - 32'h2000;
        end
        return base & PAGE_MASK;
    endfunction

    // Offer one item and hold it until it is taken. Idle first at random,
    // unless a calm stretch is running.
    task automatic send_op(input pff_pkg::t_func op, input logic [AW-1:0] a,
                           input logic [AW-1:0] e);
        while (!calm && $urandom_range(0, 99) < 21) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= op;
        i_addr     <= a;
        i_end_addr <= e;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Write one register; valid stays high so back-to-back writes need no gap.
    task automatic cfg_write(input logic [IW-1:0] idx, input logic [AW-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == pff_pkg::CFG_KSTART)
            kstart_now = val;
        else if (idx == pff_pkg::CFG_KEND)
            kend_now = val;
    endtask

    task automatic set_kernel_window(input logic [AW-1:0] ks, input logic [AW-1:0] ke);
        cfg_write(pff_pkg::CFG_KSTART, ks);
        cfg_write(pff_pkg::CFG_KEND, ke);
        i_cfg_valid <= 1'b0;
    endtask

    // Drop valid and wait for every outstanding result to come back.
    task automatic wait_idle();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_n != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    // Random mix of operations. Most ranges are short, a few run to some
    // hundreds of pages, and some are broken on purpose: start not below end,
    // misaligned start, or a range running into the address top.
    task automatic run_mix(input int n_items, input int alloc_pct, input int hold_at,
                           input int calm_upto);
        int            k;
        int            pick;
        int            sub;
        int unsigned   len;
        logic [AW-1:0] a;
        logic [AW-1:0] e;
        for (k = 0; k < n_items; k++) begin
            calm = (k < calm_upto);
            if (k == hold_at)
                hold_req = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < alloc_pct) begin
                send_op(pff_pkg::FN_ALLOC, $urandom, $urandom);
            end else if (pick < alloc_pct + (100 - alloc_pct) / 2) begin
                send_op(pff_pkg::FN_FREE, pick_addr(), $urandom);
            end else if (pick < 97) begin
                sub = $urandom_range(0, 99);
                if (sub < 4) begin
                    a = pick_addr();
                    e = a - 32'($urandom_range(0, 32'h3000));
                    // keep the end at or below the start even near address zero
                    if (e > a)
                        e = a;
                end else if (sub < 7) begin
                    a = $urandom | 32'($urandom_range(1, 12'hFFF));
                    e = $urandom;
                end else if (sub < 10) begin
                    a = 32'hFFFF_F000 - 32'($urandom_range(0, 8) << PS);
                    e = 32'hFFFF_FFFF - 32'($urandom_range(0, 12'hFFF));
                end else begin
                    a   = pick_addr();
                    len = ($urandom_range(0, 99) < 97) ? $urandom_range(0, 12)
                                                       : $urandom_range(100, 256);
                    e   = a + 32'(len << PS);
                    if ($urandom_range(0, 3) == 0)
                        e = e + 32'($urandom_range(1, 12'hFFF));
                end
                send_op(pff_pkg::FN_RANGE, a, e);
            end else begin
                send_op(pff_pkg::FN_NONE, $urandom, $urandom);
            end
        end
        calm = 1'b0;
    endtask

    // Receiver: stall in about a fifth of cycles, none during a calm stretch,
    // and once hold off for a long stretch so the block backs up to its input.
    initial begin : result_sink
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                i_out_stall <= 1'b1;
            end else if (calm) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < 21);
            end
        end
    end

    initial begin : stimulus
        logic [AW-1:0] ks;
        logic [AW-1:0] ke;
        // drive every input to a known value from the start
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= pff_pkg::CFG_KSTART;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_func      <= pff_pkg::FN_ALLOC;
        i_addr      <= '0;
        i_end_addr  <= '0;
        kstart_now  = pff_pkg::KSTART_RST;
        kend_now    = pff_pkg::KEND_RST;
        calm        = 1'b0;
        hold_req    = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, reset kernel window [1 MiB, 4 MiB).
        send_op(pff_pkg::FN_ALLOC, 32'h0, 32'h0);                 // empty stack
        send_op(pff_pkg::FN_FREE, 32'h0, 32'h0);                  // address zero is reserved
        send_op(pff_pkg::FN_FREE, 32'h0000_1001, 32'h0);          // misaligned
        send_op(pff_pkg::FN_FREE, 32'h0000_0800, 32'h0);          // misaligned, top offset bit
        send_op(pff_pkg::FN_FREE, 32'h0008_0000, 32'h0);          // first page of the low hole
        send_op(pff_pkg::FN_FREE, 32'h000F_F000, 32'h0);          // last page of the low hole
        send_op(pff_pkg::FN_FREE, 32'h0010_0000, 32'h0);          // kernel start
        send_op(pff_pkg::FN_FREE, 32'h003F_F000, 32'h0);          // last kernel page
        send_op(pff_pkg::FN_FREE, 32'h0040_0000, 32'h0);          // just past the kernel
        send_op(pff_pkg::FN_FREE, 32'h0007_F000, 32'h0);          // just below the hole
        send_op(pff_pkg::FN_FREE, 32'hFFFF_F000, 32'hFFFF_FFFF);  // highest page
        send_op(pff_pkg::FN_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // pops the highest page
        send_op(pff_pkg::FN_RANGE, 32'h0000_5000, 32'h0000_5000); // empty range
        send_op(pff_pkg::FN_RANGE, 32'h0000_6000, 32'h0000_5000); // start above end
        send_op(pff_pkg::FN_RANGE, 32'h0000_5001, 32'h0000_9000); // misaligned start
        send_op(pff_pkg::FN_RANGE, 32'h0000_5001, 32'h0000_0010); // misaligned, start above end
        send_op(pff_pkg::FN_RANGE, 32'h0008_0000, 32'h0010_0000); // whole hole, all reserved
        send_op(pff_pkg::FN_RANGE, 32'h0007_E000, 32'h0008_2000); // straddles the hole
        send_op(pff_pkg::FN_RANGE, 32'hFFFF_E000, 32'hFFFF_FFFF); // runs into the address top
        send_op(pff_pkg::FN_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // unused code
        // overfill: the walk must stop at the first dropped page
        send_op(pff_pkg::FN_RANGE, FILL_BASE, FILL_BASE + ((STACK_DEPTH + 128) << PS));
        send_op(pff_pkg::FN_FREE, 32'h0200_0000, 32'h0);          // full stack
        send_op(pff_pkg::FN_RANGE, 32'h0008_0000, 32'h0010_0000); // reserved range, full stack
        send_op(pff_pkg::FN_ALLOC, 32'h0, 32'h0);
        send_op(pff_pkg::FN_RANGE, 32'h0300_0000, 32'h0300_3000); // one push, then full
        send_op(pff_pkg::FN_ALLOC, 32'h0, 32'h0);
        wait_idle();

        // Empty kernel window at the bottom; long receiver hold-off early on.
        set_kernel_window(32'h0, 32'h0);
        run_mix(PHASE_ITEMS, 60, 40, 0);
        wait_idle();

        // Window covering almost all of the address space.
        set_kernel_window(32'h0, 32'hFFFF_FFFF);
        run_mix(PHASE_ITEMS, 40, -1, 0);
        wait_idle();

        // Inverted window, so nothing is kernel; also poke the unused index.
        cfg_write(CFG_UNUSED, $urandom);
        set_kernel_window(32'hFFFF_FFFF, 32'h0);
        run_mix(PHASE_ITEMS, 50, -1, 0);
        wait_idle();

        // Random window with unaligned bounds; open with a stretch of no idling.
        ks = $urandom;
        ke = ks + 32'($urandom_range(1, 2048) << PS) + 32'($urandom_range(0, 12'hFFF));
        set_kernel_window(ks, ke);
        run_mix(PHASE_ITEMS, 50, -1, 150);
        wait_idle();

        // Back to the reset window.
        set_kernel_window(pff_pkg::KSTART_RST, pff_pkg::KEND_RST);
        run_mix(PHASE_ITEMS, 50, -1, 0);
        wait_idle();

        // let any stray result show up before the verdict
        repeat (16) @(posedge i_clk);
        if (fail_n == 0 && pending_n == 0) begin
            $display("page_frame_free_stack_top: match");
        end else begin
            $display("page_frame_free_stack_top: mismatch");
        end
        $finish;
    end

    // Hard stop well past the slowest correct run.
    initial begin : run_limit
        #10_000_000;
        $display("page_frame_free_stack_top: mismatch");
        $finish;
    end

endmodule
